/* design/mcam_pkg.sv */
// Shared types, constants and cosine table function for the multi-channel AM modulator.
`default_nettype none

package mcam_pkg;

  localparam int unsigned NUM_FIELDS  = 4;
  localparam int unsigned MOD_W       = 16;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned COS_W       = 15;
  localparam int unsigned ENV_W       = 17;
  localparam int unsigned EC_W        = 32;
  localparam int unsigned PROD_W      = 48;
  localparam int unsigned FRAC_SHIFT  = 42;
  localparam int unsigned LIM_W       = 11;
  localparam int unsigned LANE_DEPTH  = 3;
  localparam int unsigned MERGE_DEPTH = 3;
  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd16384;
  localparam logic [ENV_W-1:0]   ENV_BIAS    = 17'd8192;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

  localparam logic [63:0] COS_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_STEP_A  = 3'd0,
    CFG_STEP_B  = 3'd1,
    CFG_STEP_C  = 3'd2,
    CFG_STEP_D  = 3'd3,
    CFG_LEVEL_A = 3'd4,
    CFG_LEVEL_B = 3'd5,
    CFG_LEVEL_C = 3'd6,
    CFG_LEVEL_D = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [MOD_W-1:0] mod_a;
    logic signed [MOD_W-1:0] mod_b;
    logic signed [MOD_W-1:0] mod_c;
    logic signed [MOD_W-1:0] mod_d;
  } in_t;

  typedef struct packed {
    logic signed [7:0] dac_sample;
    logic              second_copy;
  } out_t;

  typedef struct packed {
    logic adv;
    logic acc;
  } lane_ctrl_t;

  // Quarter-wave cosine entry r of a table with 2^qbits steps, unsigned Q0.15.
  function automatic logic [COS_W-1:0] cos_entry(input int unsigned r,
                                                 input int unsigned qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] v;
    x    = (HALF_PI_Q30 * 64'(r)) >> qbits;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    acc  = term;
    for (int n = 1; n <= 12; n++) begin
      term = (term * x2) >> 30;
      term = term / COS_DIV[n-1];
      if (n[0]) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[COS_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/mcam_lane.sv */
// One carrier lane: phase accumulator, cosine ROM, envelope and gain multipliers.
`default_nettype none

module mcam_lane #(
  parameter int unsigned COS_TABLE_BITS = 10
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire mcam_pkg::lane_ctrl_t               ctrl_i,
  input  wire logic signed [mcam_pkg::MOD_W-1:0]  mod_i,
  input  wire logic [mcam_pkg::STEP_W-1:0]        step_i,
  input  wire logic [mcam_pkg::LEVEL_W-1:0]       level_i,
  output logic signed [mcam_pkg::PROD_W-1:0]      prod_o
);

  localparam int unsigned QBits = COS_TABLE_BITS - 2;
  localparam int unsigned QSize = 1 << QBits;
  localparam int unsigned AddrW = QBits + 1;

  logic [mcam_pkg::COS_W-1:0] cos_rom [QSize+1];

  for (genvar r = 0; r <= QSize; r++) begin : g_rom
    assign cos_rom[r] = mcam_pkg::cos_entry(r, QBits);
  end

  logic [mcam_pkg::STEP_W-1:0]       phase_q;
  logic [COS_TABLE_BITS-1:0]         tbl_idx;
  logic [1:0]                        quad;
  logic [QBits-1:0]                  frac_idx;
  logic [AddrW-1:0]                  rom_addr;

  logic [mcam_pkg::COS_W-1:0]        mag_q;
  logic                              neg_q;
  logic signed [mcam_pkg::ENV_W-1:0] env_q;
  logic [mcam_pkg::LEVEL_W-1:0]      lvl1_q;

  logic signed [mcam_pkg::ENV_W-1:0] cos_val;
  logic signed [2*mcam_pkg::ENV_W-1:0] ec_full;
  logic signed [mcam_pkg::EC_W-1:0]  ec_q;
  logic [mcam_pkg::LEVEL_W-1:0]      lvl2_q;

  logic signed [mcam_pkg::EC_W+mcam_pkg::LEVEL_W:0] prod_full;
  logic signed [mcam_pkg::PROD_W-1:0] prod_q;

  assign tbl_idx  = phase_q[mcam_pkg::STEP_W-1 -: COS_TABLE_BITS];
  assign quad     = tbl_idx[COS_TABLE_BITS-1 -: 2];
  assign frac_idx = tbl_idx[QBits-1:0];
  assign rom_addr = quad[0] ? (AddrW'(QSize) - {1'b0, frac_idx}) : {1'b0, frac_idx};

  // advance the carrier on every accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctrl_i.acc) begin
      phase_q <= phase_q + step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      mag_q  <= cos_rom[rom_addr];
      neg_q  <= quad[0] ^ quad[1];
      env_q  <= $signed(mcam_pkg::ENV_BIAS) + mcam_pkg::ENV_W'(mod_i);
      lvl1_q <= level_i;
    end
  end

  assign cos_val = neg_q ? -$signed({2'b00, mag_q}) : $signed({2'b00, mag_q});
  assign ec_full = env_q * cos_val;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      ec_q   <= ec_full[mcam_pkg::EC_W-1:0];
      lvl2_q <= lvl1_q;
    end
  end

  assign prod_full = ec_q * $signed({1'b0, lvl2_q});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      prod_q <= prod_full[mcam_pkg::PROD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

/* design/mcam_merge.sv */
// Merge stage: sums the lane products, scales, divides by the channel count and clamps.
`default_nettype none

module mcam_merge #(
  parameter int unsigned CHANNELS = 4
) (
  input  wire                                        clk_i,
  input  wire                                        adv_i,
  input  wire logic signed [mcam_pkg::PROD_W-1:0]    prod_i [CHANNELS],
  output logic signed [7:0]                          sample_o
);

  localparam int unsigned SumW   = mcam_pkg::PROD_W + $clog2(CHANNELS);
  localparam int unsigned ScW    = SumW + 6;
  localparam int unsigned UW     = ScW - mcam_pkg::FRAC_SHIFT;
  localparam int unsigned LimW   = mcam_pkg::LIM_W;
  localparam int unsigned Lim    = 129 * CHANNELS - 1;
  localparam int unsigned DivS   = LimW + $clog2(CHANNELS);
  localparam int unsigned Recip  = ((1 << DivS) + CHANNELS - 1) / CHANNELS;
  localparam int unsigned RecipW = DivS + 1;

  logic signed [SumW-1:0] sum_d;
  logic signed [SumW-1:0] sum_q;
  logic [SumW-1:0]        mag;
  logic [ScW-1:0]         scaled;
  logic [UW-1:0]          quot_hi;
  logic [LimW-1:0]        lim_q;
  logic                   neg_q;
  logic [LimW+RecipW-1:0] recip_prod;
  logic [8:0]             qmag;
  logic signed [7:0]      sample_d;
  logic signed [7:0]      sample_q;

  always_comb begin
    sum_d = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sum_d = sum_d + SumW'(prod_i[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum_q <= sum_d;
    end
  end

  assign mag     = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign scaled  = (ScW'(mag) << 5) + (ScW'(mag) << 4);
  assign quot_hi = scaled[ScW-1:mcam_pkg::FRAC_SHIFT];

  // hold the magnitude just above the clamp point so the divide stays narrow
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lim_q <= (quot_hi > UW'(Lim)) ? LimW'(Lim) : quot_hi[LimW-1:0];
      neg_q <= sum_q[SumW-1];
    end
  end

  assign recip_prod = (LimW+RecipW)'(lim_q) * (LimW+RecipW)'(Recip);
  assign qmag       = recip_prod[DivS +: 9];

  always_comb begin
    if (neg_q) begin
      sample_d = 8'(-$signed(qmag));
    end else if (qmag > 9'd127) begin
      sample_d = 8'sd127;
    end else begin
      sample_d = $signed(qmag[7:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

/* design/multi_channel_am_modulator.sv */
// Top level of the multi-channel AM modulator: configuration, lanes, merge and output repeat.
`default_nettype none

// Each request carries one modulating sample per channel; every channel runs its own
// 32-bit phase accumulator into a quarter-wave cosine ROM, forms (1 + m/8192) * cos * level,
// and the merge stage sums the channels, scales by 48/CHANNELS, truncates toward zero
// and clamps to -128..127. Every sample leaves OUTPUT_REPEAT times, second_copy high on
// all but the first. The datapath is a stalling pipeline that holds several requests at
// once; it stalls only while a finished sample waits and the output register still has
// copies to send, one copy per cycle while out_ready_i is high.
// Configuration writes are taken in any cycle and must only come while the block is idle.
module multi_channel_am_modulator #(
  parameter int unsigned CHANNELS       = 4,
  parameter int unsigned COS_TABLE_BITS = 10,
  parameter int unsigned OUTPUT_REPEAT  = 2
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire mcam_pkg::in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output mcam_pkg::out_t                         out_data_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mcam_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  wire logic [mcam_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int unsigned Depth = mcam_pkg::LANE_DEPTH + mcam_pkg::MERGE_DEPTH;
  localparam int unsigned CntW  = (OUTPUT_REPEAT > 1) ? $clog2(OUTPUT_REPEAT) : 1;
  localparam int unsigned NF    = mcam_pkg::NUM_FIELDS;

  logic [mcam_pkg::STEP_W-1:0]  step_q  [NF];
  logic [mcam_pkg::LEVEL_W-1:0] level_q [NF];

  logic signed [mcam_pkg::MOD_W-1:0]  mods   [NF];
  logic signed [mcam_pkg::PROD_W-1:0] prods  [CHANNELS];
  logic signed [7:0]                  merged;

  logic [Depth-1:0]   vld_q;
  logic               out_valid_q;
  logic [CntW-1:0]    copy_q;
  logic signed [7:0]  dac_q;
  logic               last_copy;
  logic               out_free;
  logic               stall;
  logic               load_out;
  mcam_pkg::lane_ctrl_t ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NF; i++) begin
        step_q[i]  <= '0;
        level_q[i] <= mcam_pkg::LEVEL_RESET;
      end
    end else if (cfg_valid_i) begin
      unique case (mcam_pkg::cfg_idx_e'(cfg_addr_i))
        mcam_pkg::CFG_STEP_A:  step_q[0]  <= cfg_data_i;
        mcam_pkg::CFG_STEP_B:  step_q[1]  <= cfg_data_i;
        mcam_pkg::CFG_STEP_C:  step_q[2]  <= cfg_data_i;
        mcam_pkg::CFG_STEP_D:  step_q[3]  <= cfg_data_i;
        mcam_pkg::CFG_LEVEL_A: level_q[0] <= cfg_data_i[mcam_pkg::LEVEL_W-1:0];
        mcam_pkg::CFG_LEVEL_B: level_q[1] <= cfg_data_i[mcam_pkg::LEVEL_W-1:0];
        mcam_pkg::CFG_LEVEL_C: level_q[2] <= cfg_data_i[mcam_pkg::LEVEL_W-1:0];
        mcam_pkg::CFG_LEVEL_D: level_q[3] <= cfg_data_i[mcam_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign mods[0] = in_data_i.mod_a;
  assign mods[1] = in_data_i.mod_b;
  assign mods[2] = in_data_i.mod_c;
  assign mods[3] = in_data_i.mod_d;

  assign last_copy  = (copy_q == CntW'(OUTPUT_REPEAT - 1));
  assign out_free   = !out_valid_q || (out_ready_i && last_copy);
  assign stall      = vld_q[Depth-1] && !out_free;
  assign in_ready_o = !stall;
  assign ctrl.adv   = !stall;
  assign ctrl.acc   = in_valid_i && !stall;
  assign load_out   = vld_q[Depth-1] && !stall;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    if (c < NF) begin : g_live
      mcam_lane #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .mod_i  (mods[c]),
        .step_i (step_q[c]),
        .level_i(level_q[c]),
        .prod_o (prods[c])
      );
    end else begin : g_silent
      mcam_lane #(
        .COS_TABLE_BITS(COS_TABLE_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl),
        .mod_i  ('0),
        .step_i ('0),
        .level_i('0),
        .prod_o (prods[c])
      );
    end
  end

  mcam_merge #(
    .CHANNELS(CHANNELS)
  ) u_merge (
    .clk_i   (clk_i),
    .adv_i   (ctrl.adv),
    .prod_i  (prods),
    .sample_o(merged)
  );

  // advance the valid marks with the datapath, hold them on a stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ctrl.adv) begin
      vld_q <= {vld_q[Depth-2:0], ctrl.acc};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      copy_q      <= '0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
      copy_q      <= '0;
    end else if (out_valid_q && out_ready_i) begin
      if (last_copy) begin
        out_valid_q <= 1'b0;
      end else begin
        copy_q <= copy_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      dac_q <= merged;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign out_data_o.dac_sample  = dac_q;
  assign out_data_o.second_copy = (copy_q != '0);

  a_repeat_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_copy
      |=> out_valid_o && out_data_o.second_copy && $stable(out_data_o.dac_sample))
    else $error("repeated copy lost or changed");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_copy && !load_out |=> !out_valid_o)
    else $error("output stays valid after last copy");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> vld_q[Depth-1] && out_valid_o)
    else $error("request refused without a waiting result");

endmodule

`default_nettype wire

/* test/multi_channel_am_modulator_tb.sv */
// Self-checking testbench for the multi-channel AM modulator: directed table, then random requests.
module multi_channel_am_modulator_tb;
  import mcam_pkg::*;

  localparam int unsigned CHANNELS       = 4;
  localparam int unsigned COS_TABLE_BITS = 10;
  localparam int unsigned OUTPUT_REPEAT  = 2;
  localparam int unsigned QUARTER_BITS   = COS_TABLE_BITS - 2;
  localparam int unsigned QUARTER        = 1 << QUARTER_BITS;
  localparam int          ENVELOPE_ONE   = 8192;
  localparam int          CLK_HALF       = 5;
  localparam int          RESET_CYCLES   = 3;
  localparam int          RANDOM_PHASES  = 3;
  localparam int          RANDOM_BLOCKS  = 4;
  localparam int          BLOCK_ITEMS    = 104;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          TIMEOUT_CYCLES = 200000;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    cfg_idx_e                idx;
    logic [CFG_DATA_W-1:0]   data;
    in_t                     item;
    logic                    typed;
    logic signed [7:0]       dac;
  } stim_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_t                   in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_t                  out_data_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  int                cos_quarter [QUARTER+1];
  logic [31:0]       phase_acc [CHANNELS];
  logic [31:0]       step_cfg [NUM_FIELDS];
  logic [15:0]       level_cfg [NUM_FIELDS];
  out_t              dac_expect_q [$];
  stim_row_t         directed_rows [$];
  bit                failed = 1'b0;
  int                sender_idle_pct = 0;
  int                receiver_idle_pct = 0;

  multi_channel_am_modulator #(
    .CHANNELS       (CHANNELS),
    .COS_TABLE_BITS (COS_TABLE_BITS),
    .OUTPUT_REPEAT  (OUTPUT_REPEAT)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  function automatic void build_cos_quarter();
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned acc;
    longint unsigned v;
    for (int r = 0; r <= int'(QUARTER); r++) begin
      x    = (HALF_PI_Q30 * longint'(r)) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = term;
      for (int n = 1; n <= 12; n++) begin
        term = (term * x2) >> 30;
        term = term / longint'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
      v = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
        v = 64'd32767;
      end
      cos_quarter[r] = int'(v);
    end
  endfunction

  function automatic int carrier_cos(logic [31:0] phase);
    logic [COS_TABLE_BITS-1:0] idx;
    logic [1:0]                quad;
    int                        r;
    idx  = phase[31 -: COS_TABLE_BITS];
    quad = idx[QUARTER_BITS +: 2];
    r    = int'(idx[QUARTER_BITS-1:0]);
    case (quad)
      2'd0:    return cos_quarter[r];
      2'd1:    return -cos_quarter[int'(QUARTER) - r];
      2'd2:    return -cos_quarter[r];
      default: return cos_quarter[int'(QUARTER) - r];
    endcase
  endfunction

  // Advance the carrier phases and return the clamped DAC sample for one request.
  function automatic logic signed [7:0] predict_dac(in_t d);
    int     mods [NUM_FIELDS];
    longint acc_sum;
    longint scaled;
    int     cv;
    int     env;
    mods[0] = int'($signed(d.mod_a));
    mods[1] = int'($signed(d.mod_b));
    mods[2] = int'($signed(d.mod_c));
    mods[3] = int'($signed(d.mod_d));
    acc_sum = 0;
    for (int c = 0; c < int'(CHANNELS); c++) begin
      cv = carrier_cos(phase_acc[c]);
      if (c < int'(NUM_FIELDS)) begin
        phase_acc[c] = phase_acc[c] + step_cfg[c];
        env = ENVELOPE_ONE + mods[c];
        acc_sum += longint'(env) * longint'(cv) * longint'(level_cfg[c]);
      end
    end
    scaled = (acc_sum * 48) / (longint'(CHANNELS) << 42);
    if (scaled > 127) begin
      scaled = 127;
    end
    if (scaled < -128) begin
      scaled = -128;
    end
    return scaled[7:0];
  endfunction

  function automatic void add_item(logic [MOD_W-1:0] a, logic [MOD_W-1:0] b,
                                   logic [MOD_W-1:0] c, logic [MOD_W-1:0] d,
                                   logic typed, logic signed [7:0] dac);
    stim_row_t row;
    row            = '0;
    row.kind       = ROW_ITEM;
    row.item.mod_a = a;
    row.item.mod_b = b;
    row.item.mod_c = c;
    row.item.mod_d = d;
    row.typed      = typed;
    row.dac        = dac;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    directed_rows.push_back(row);
  endfunction

  function automatic logic [MOD_W-1:0] random_mod();
    case ($urandom_range(7, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return MOD_W'($urandom_range(4095, 0)) - 16'd2048;
      3:       return 16'hE000 + MOD_W'($urandom_range(63, 0));
      default: return MOD_W'($urandom);
    endcase
  endfunction

  task automatic send_item(in_t d, logic typed, logic signed [7:0] typed_dac);
    int                gap;
    logic signed [7:0] dac;
    out_t              copy;
    gap = 0;
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      gap++;
    end
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    dac = predict_dac(d);
    if (typed) begin
      dac = typed_dac;
    end
    for (int k = 0; k < int'(OUTPUT_REPEAT); k++) begin
      copy.dac_sample  = dac;
      copy.second_copy = (k > 0);
      dac_expect_q.push_back(copy);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (dac_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (int'(idx) < int'(NUM_FIELDS)) begin
      step_cfg[idx] = data;
    end else begin
      level_cfg[int'(idx) - int'(NUM_FIELDS)] = data[LEVEL_W-1:0];
    end
  endtask

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] data;
    wait_drained();
    for (int i = 0; i < 2 * int'(NUM_FIELDS); i++) begin
      if (i < int'(NUM_FIELDS)) begin
        case ($urandom_range(4, 0))
          0:       data = '0;
          1:       data = 32'h8000_0000;
          default: data = $urandom_range(32'h8000_0000, 0);
        endcase
      end else begin
        data = $urandom;
        case ($urandom_range(4, 0))
          0:       data[15:0] = 16'h0000;
          1:       data[15:0] = 16'hFFFF;
          2:       data[15:0] = 16'h4000;
          default: ;
        endcase
      end
      write_reg(cfg_idx_e'(i), data);
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dac_expect_q.size() == 0) begin
        $error("unexpected result: dac_sample %0d second_copy %0d",
               $signed(out_data_o.dac_sample), out_data_o.second_copy);
        failed = 1'b1;
      end else begin
        want = dac_expect_q.pop_front();
        if (out_data_o.dac_sample !== want.dac_sample) begin
          $error("dac_sample: expected %0d, got %0d",
                 $signed(want.dac_sample), $signed(out_data_o.dac_sample));
          failed = 1'b1;
        end
        if (out_data_o.second_copy !== want.second_copy) begin
          $error("second_copy: expected %0d, got %0d",
                 want.second_copy, out_data_o.second_copy);
          failed = 1'b1;
        end
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99, 0) >= receiver_idle_pct);
  end

  initial begin
    #(CLK_HALF * 2 * TIMEOUT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    in_t       d;
    build_cos_quarter();
    for (int c = 0; c < int'(CHANNELS); c++) begin
      phase_acc[c] = '0;
    end
    for (int c = 0; c < int'(NUM_FIELDS); c++) begin
      step_cfg[c]  = '0;
      level_cfg[c] = LEVEL_RESET;
    end

    // Reset settings: carriers sit at phase zero, unity gain.
    add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'sd47);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 8'sd127);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 8'sh80);
    add_item(16'hE000, 16'hE000, 16'hE000, 16'hE000, 1'b1, 8'sd0);
    add_item(16'h7FFF, 16'h8000, 16'h0000, 16'hE000, 1'b0, 8'sd0);
    add_item(16'h5555, 16'hAAAA, 16'h0001, 16'hFFFF, 1'b0, 8'sd0);
    // Walk all quadrants and wrap the phase; upper level bits get masked.
    add_cfg(CFG_STEP_A, 32'h8000_0000);
    add_cfg(CFG_STEP_B, 32'h4000_0000);
    add_cfg(CFG_STEP_C, 32'h0040_0000);
    add_cfg(CFG_STEP_D, 32'h7FFF_FFFF);
    add_cfg(CFG_LEVEL_A, 32'hFFFF_FFFF);
    add_cfg(CFG_LEVEL_B, 32'h0000_0000);
    add_cfg(CFG_LEVEL_C, 32'h1234_4000);
    add_cfg(CFG_LEVEL_D, 32'h0000_8000);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 8'sd0);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 8'sd0);
    add_item(16'h0000, 16'h7FFF, 16'h8000, 16'h1000, 1'b0, 8'sd0);
    add_item(16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001, 1'b0, 8'sd0);
    add_item(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 1'b0, 8'sd0);
    add_item(16'h8000, 16'h8000, 16'h0000, 16'h0000, 1'b0, 8'sd0);
    add_item(16'h1234, 16'hEDCB, 16'h7FFF, 16'h8000, 1'b0, 8'sd0);
    add_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 8'sd0);
    add_cfg(CFG_LEVEL_A, 32'h0000_FFFF);
    add_cfg(CFG_LEVEL_B, 32'h0000_FFFF);
    add_cfg(CFG_LEVEL_C, 32'h0000_FFFF);
    add_cfg(CFG_LEVEL_D, 32'h0000_FFFF);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 8'sd0);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 8'sd0);
    // All gains zero: silence whatever the modulation.
    add_cfg(CFG_LEVEL_A, 32'h0000_0000);
    add_cfg(CFG_LEVEL_B, 32'h0000_0000);
    add_cfg(CFG_LEVEL_C, 32'h0000_0000);
    add_cfg(CFG_LEVEL_D, 32'h0000_0000);
    add_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 8'sd0);
    add_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 8'sd0);

    receiver_idle_pct = 52;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        wait_drained();
        write_reg(row.idx, row.data);
      end else begin
        send_item(row.item, row.typed, row.dac);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct   = 37;
          receiver_idle_pct = 52;
        end
        1: begin
          sender_idle_pct   = 52;
          receiver_idle_pct = 37;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
        random_settings();
        repeat (BLOCK_ITEMS) begin
          d.mod_a = random_mod();
          d.mod_b = random_mod();
          d.mod_c = random_mod();
          d.mod_d = random_mod();
          send_item(d, 1'b0, 8'sd0);
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/mcam_pkg.sv
design/mcam_lane.sv
design/mcam_merge.sv
design/multi_channel_am_modulator.sv
test/multi_channel_am_modulator_tb.sv
